### sv/bfiq_pkg.sv
// ----------------------------------------------------------------------------
// bfiq_pkg
// types, codes and hash constants shared by the bloom filter block
// ----------------------------------------------------------------------------
package bfiq_pkg;

    typedef struct packed {
        logic       command;
        logic [7:0] key_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic        matched;
        logic        key_too_long;
        logic [31:0] element_count;
    } t_out_word;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        REG_FILTER_BYTES = 2'd0,
        REG_HASH_COUNT   = 2'd1,
        REG_TWEAK        = 2'd2
    } t_reg_idx;

    localparam logic [15:0] FILTER_BYTES_RST = 16'd36000;
    localparam logic [5:0]  HASH_COUNT_RST   = 6'd1;

    localparam logic [31:0] SEED_STEP = 32'hfba4c795;
    localparam logic [31:0] MM_C1     = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2     = 32'h1b873593;
    localparam logic [31:0] MM_ADD    = 32'he6546b64;
    localparam logic [31:0] MM_F1     = 32'h85ebca6b;
    localparam logic [31:0] MM_F2     = 32'hc2b2ae35;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_IDLE,
        OP_CLEAR,
        OP_STORE,
        OP_HINIT,
        OP_KRD,
        OP_KACC,
        OP_MUL1,
        OP_MUL2,
        OP_MIX,
        OP_FIN0,
        OP_FIN1,
        OP_FIN2,
        OP_FIN3,
        OP_FIN4,
        OP_DIV,
        OP_BRD,
        OP_BCHK,
        OP_DONE
    } t_op;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic ovf;
        logic nhash_zero;
        logic blk_end;
        logic key_end;
        logic key_done;
        logic div_last;
        logic bit_set;
        logic hash_last;
        logic query;
    } t_dp_stat;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        rotl32 = (x << r) | (x >> (32 - r));
    endfunction

endpackage

### sv/bfiq_ctrl.sv
// ----------------------------------------------------------------------------
// bfiq_ctrl
// sequencer for clearing, key capture, murmur3 passes, reduction and lookup
// ----------------------------------------------------------------------------
module bfiq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_last,
    input  bfiq_pkg::t_dp_stat i_stat,
    output bfiq_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy
);
    import bfiq_pkg::*;

    typedef enum logic [4:0] {
        S_CLR, S_IDLE, S_CHECK, S_HINIT, S_KRD, S_KACC, S_MUL1, S_MUL2, S_MIX,
        S_FIN0, S_FIN1, S_FIN2, S_FIN3, S_FIN4, S_DIV, S_BRD, S_BCHK, S_DONE
    } t_state;

    t_state r_state, n_state;
    t_op    op;

    always_comb begin
        n_state = r_state;
        op      = OP_IDLE;
        unique case (r_state)
            S_CLR: begin
                op = OP_CLEAR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    op = OP_STORE;
                    if (i_last) n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.ovf || i_stat.nhash_zero) n_state = S_DONE;
                else n_state = S_HINIT;
            end
            S_HINIT: begin
                op      = OP_HINIT;
                n_state = S_KRD;
            end
            S_KRD: begin
                op      = OP_KRD;
                n_state = S_KACC;
            end
            S_KACC: begin
                op = OP_KACC;
                if (i_stat.blk_end || i_stat.key_end) n_state = S_MUL1;
                else n_state = S_KRD;
            end
            S_MUL1: begin
                op      = OP_MUL1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                op      = OP_MUL2;
                n_state = S_MIX;
            end
            S_MIX: begin
                op = OP_MIX;
                if (i_stat.key_done) n_state = S_FIN0;
                else n_state = S_KRD;
            end
            S_FIN0: begin
                op      = OP_FIN0;
                n_state = S_FIN1;
            end
            S_FIN1: begin
                op      = OP_FIN1;
                n_state = S_FIN2;
            end
            S_FIN2: begin
                op      = OP_FIN2;
                n_state = S_FIN3;
            end
            S_FIN3: begin
                op      = OP_FIN3;
                n_state = S_FIN4;
            end
            S_FIN4: begin
                op      = OP_FIN4;
                n_state = S_DIV;
            end
            S_DIV: begin
                op = OP_DIV;
                if (i_stat.div_last) n_state = S_BRD;
            end
            S_BRD: begin
                op      = OP_BRD;
                n_state = S_BCHK;
            end
            S_BCHK: begin
                op = OP_BCHK;
                if ((i_stat.query && !i_stat.bit_set) || i_stat.hash_last) n_state = S_DONE;
                else n_state = S_HINIT;
            end
            S_DONE: begin
                op      = OP_DONE;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.op = op;
    assign o_busy   = (r_state != S_IDLE);

endmodule

### sv/bfiq_datapath.sv
// ----------------------------------------------------------------------------
// bfiq_datapath
// key buffer, murmur3 hash unit, bit-serial reducer and bit array memory
// ----------------------------------------------------------------------------
module bfiq_datapath #(
    parameter int MAX_FILTER_BYTES = 36000,
    parameter int MAX_KEY_BYTES    = 80,
    parameter int MAX_HASHES       = 50
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bfiq_pkg::t_dp_cmd  i_cmd,
    input  bfiq_pkg::t_in_word i_word,
    input  logic [15:0]        i_filter_bytes,
    input  logic [5:0]         i_hash_count,
    input  logic [31:0]        i_tweak,
    output bfiq_pkg::t_dp_stat o_stat,
    output logic               o_done,
    output bfiq_pkg::t_out_word o_word
);
    import bfiq_pkg::*;

    localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KLW = $clog2(MAX_KEY_BYTES + 1);
    localparam int BAW = (MAX_FILTER_BYTES > 1) ? $clog2(MAX_FILTER_BYTES) : 1;
    localparam int NBB = $clog2(MAX_FILTER_BYTES + 1);
    localparam int NBW = NBB + 3;
    localparam int HW  = $clog2(MAX_HASHES + 1);

    logic [7:0] key_mem [MAX_KEY_BYTES];
    logic [7:0] bit_mem [MAX_FILTER_BYTES];

    logic [KLW-1:0] r_key_len, r_pos;
    logic           r_ovf, r_query, r_full, r_match;
    logic [1:0]     r_lane;
    logic [NBW-1:0] r_nbits, r_rem;
    logic [HW-1:0]  r_nhash, r_hidx;
    logic [31:0]    r_seed, r_h, r_k, r_count;
    logic [7:0]     r_kd, r_bd;
    logic [4:0]     r_dcnt;
    logic [BAW-1:0] r_clr_addr;
    logic           r_done;
    t_out_word      r_out;

    logic [16:0]    fb17;
    logic [NBB-1:0] nb;
    logic [HW-1:0]  nh;
    logic [NBW:0]   div_t;
    logic [31:0]    fx;
    logic [7:0]     bmask;
    logic [BAW-1:0] baddr;
    logic           bwe;
    logic [BAW-1:0] bwa;
    logic [7:0]     bwd;

    // clamp the filter size and hash count sampled at the last byte
    always_comb begin
        fb17 = {1'b0, i_filter_bytes};
        if (fb17 > 17'(MAX_FILTER_BYTES)) nb = NBB'(MAX_FILTER_BYTES);
        else if (fb17 == 17'd0) nb = NBB'(1);
        else nb = NBB'(fb17);
        if ({1'b0, i_hash_count} > 7'(MAX_HASHES)) nh = HW'(MAX_HASHES);
        else nh = HW'(i_hash_count);
    end

    assign div_t = {r_rem, r_h[31]};
    assign fx    = r_h ^ 32'(r_key_len);
    assign bmask = 8'(1) << r_rem[2:0];
    assign baddr = BAW'(r_rem >> 3);

    // key buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_STORE && r_key_len < KLW'(MAX_KEY_BYTES)) begin
            key_mem[r_key_len[KAW-1:0]] <= i_word.key_byte;
        end
        r_kd <= key_mem[r_pos[KAW-1:0]];
    end

    // bit array, shared by the clearing sweep and the read-modify-write
    always_comb begin
        bwe = 1'b0;
        bwa = r_clr_addr;
        bwd = 8'd0;
        if (i_cmd.op == OP_CLEAR) begin
            bwe = 1'b1;
        end else if (i_cmd.op == OP_BCHK && !r_query) begin
            bwe = 1'b1;
            bwa = baddr;
            bwd = r_bd | bmask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (bwe) bit_mem[bwa] <= bwd;
        r_bd <= bit_mem[baddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len  <= '0;
            r_ovf      <= 1'b0;
            r_count    <= '0;
            r_clr_addr <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (i_cmd.op)
                OP_CLEAR: r_clr_addr <= r_clr_addr + BAW'(1);
                OP_STORE: begin
                    if (r_key_len < KLW'(MAX_KEY_BYTES)) r_key_len <= r_key_len + KLW'(1);
                    else r_ovf <= 1'b1;
                    if (i_word.last_byte) begin
                        r_query <= i_word.command;
                        r_nbits <= {nb, 3'b000};
                        r_nhash <= nh;
                        r_seed  <= i_tweak;
                        r_hidx  <= '0;
                        r_match <= 1'b1;
                    end
                end
                OP_HINIT: begin
                    r_h    <= r_seed;
                    r_pos  <= '0;
                    r_lane <= 2'd0;
                end
                OP_KACC: begin
                    if (r_lane == 2'd0) r_k <= {24'd0, r_kd};
                    else r_k[8*r_lane +: 8] <= r_kd;
                    r_full <= (r_lane == 2'd3);
                    r_lane <= r_lane + 2'd1;
                    r_pos  <= r_pos + KLW'(1);
                end
                OP_MUL1: r_k <= r_k * MM_C1;
                OP_MUL2: r_k <= rotl32(r_k, 15) * MM_C2;
                OP_MIX: begin
                    if (r_full) r_h <= rotl32(r_h ^ r_k, 13) * 32'd5 + MM_ADD;
                    else r_h <= r_h ^ r_k;
                end
                OP_FIN0: r_h <= fx ^ (fx >> 16);
                OP_FIN1: r_h <= r_h * MM_F1;
                OP_FIN2: r_h <= r_h ^ (r_h >> 13);
                OP_FIN3: r_h <= r_h * MM_F2;
                OP_FIN4: begin
                    r_h    <= r_h ^ (r_h >> 16);
                    r_rem  <= '0;
                    r_dcnt <= '0;
                end
                OP_DIV: begin
                    // one quotient bit per cycle, only the remainder is kept
                    if (div_t >= {1'b0, r_nbits}) r_rem <= NBW'(div_t - {1'b0, r_nbits});
                    else r_rem <= NBW'(div_t);
                    r_h    <= r_h << 1;
                    r_dcnt <= r_dcnt + 5'd1;
                end
                OP_BCHK: begin
                    if (r_query && (r_bd & bmask) == 8'd0) r_match <= 1'b0;
                    r_hidx <= r_hidx + HW'(1);
                    r_seed <= r_seed + SEED_STEP;
                end
                OP_DONE: begin
                    r_done              <= 1'b1;
                    r_out.key_too_long  <= r_ovf;
                    r_out.matched       <= !r_ovf && r_query && r_match;
                    if (!r_ovf && r_query == CMD_INSERT) begin
                        r_count             <= r_count + 32'd1;
                        r_out.element_count <= r_count + 32'd1;
                    end else begin
                        r_out.element_count <= r_count;
                    end
                    r_key_len <= '0;
                    r_ovf     <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_stat.clr_last   = (r_clr_addr == BAW'(MAX_FILTER_BYTES - 1));
        o_stat.ovf        = r_ovf;
        o_stat.nhash_zero = (r_nhash == '0);
        o_stat.blk_end    = (r_lane == 2'd3);
        o_stat.key_end    = ((r_pos + KLW'(1)) == r_key_len);
        o_stat.key_done   = (r_pos == r_key_len);
        o_stat.div_last   = (r_dcnt == 5'd31);
        o_stat.bit_set    = ((r_bd & bmask) != 8'd0);
        o_stat.hash_last  = ((r_hidx + HW'(1)) == r_nhash);
        o_stat.query      = r_query;
    end

    assign o_done = r_done;
    assign o_word = r_out;

endmodule

### sv/bloom_filter_insert_query.sv
// ----------------------------------------------------------------------------
// bloom_filter_insert_query
// bloom filter with murmur3-32 hashing over byte-streamed keys
// ----------------------------------------------------------------------------
// A key byte word is taken on each edge with start high and busy low. Bytes
// that are not last leave busy low, so the next byte may follow at once. At
// the last byte the block goes busy and runs hash_count murmur3 passes one
// after another through one shared hash unit and one bit-serial reducer; each
// pass loads the seed, reads and accumulates each key byte, multiplies and
// mixes each 4-byte block, runs the finalization, reduces modulo the filter
// size in bits and then reads and checks or updates the bit array. Busy also
// covers a check for a long key or zero hashes ahead of the passes and a step
// to form the result after them; a failed query bit ends early.
// One result word appears on o_word with o_done high for a single cycle and
// cannot be held off. After reset the bit array is swept to zero, one byte
// per cycle, with busy high; registers can be written meanwhile.
module bloom_filter_insert_query #(
    parameter int MAX_FILTER_BYTES = 36000,
    parameter int MAX_KEY_BYTES    = 80,
    parameter int MAX_HASHES       = 50
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // item port
    input  logic                start,
    output logic                busy,
    input  bfiq_pkg::t_in_word  i_word,
    output logic                o_done,
    output bfiq_pkg::t_out_word o_word,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import bfiq_pkg::*;

    logic [15:0] r_filter_bytes;
    logic [5:0]  r_hash_count;
    logic [31:0] r_tweak;
    t_reg_idx    reg_idx;
    logic        cfg_we;
    t_dp_cmd     cmd;
    t_dp_stat    stat;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_we  = psel && penable && pwrite && pready;

    // register file, writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_bytes <= FILTER_BYTES_RST;
            r_hash_count   <= HASH_COUNT_RST;
            r_tweak        <= '0;
        end else if (cfg_we) begin
            unique case (reg_idx)
                REG_FILTER_BYTES: r_filter_bytes <= pwdata[15:0];
                REG_HASH_COUNT:   r_hash_count   <= pwdata[5:0];
                REG_TWEAK:        r_tweak        <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FILTER_BYTES: prdata = {16'd0, r_filter_bytes};
            REG_HASH_COUNT:   prdata = {26'd0, r_hash_count};
            REG_TWEAK:        prdata = r_tweak;
            default:          prdata = '0;
        endcase
    end

    // sequencer: clearing sweep, key capture and hash passes
    bfiq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_last  (i_word.last_byte),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // key buffer, hash unit, reducer and bit array
    bfiq_datapath #(
        .MAX_FILTER_BYTES (MAX_FILTER_BYTES),
        .MAX_KEY_BYTES    (MAX_KEY_BYTES),
        .MAX_HASHES       (MAX_HASHES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_word         (i_word),
        .i_filter_bytes (r_filter_bytes),
        .i_hash_count   (r_hash_count),
        .i_tweak        (r_tweak),
        .o_stat         (stat),
        .o_done         (o_done),
        .o_word         (o_word)
    );

    // a result word never lasts longer than one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");

    // a dropped key never reports a match
    a_long_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_word.key_too_long) |-> !o_word.matched)
        else $error("overlong key matched");

    // reset always starts the clearing sweep
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> busy) else $error("not busy after reset");

endmodule
